@@ rtl/core/lcal_pkg.sv @@
// Shared types and constants of the binary-lifting common ancestor core.
`default_nettype none
package lcal_pkg;

	localparam int NODE_W = 10;
	localparam logic [NODE_W-1:0] LVL_MAX = 10'd1023;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		RES_ZERO   = 2'd0,
		RES_NODE_A = 2'd1,
		RES_U      = 2'd2,
		RES_RD     = 2'd3
	} res_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     cap;       // latch input item, read both levels
		logic     ld_start;  // write level and entry 0 of loaded node
		logic     ld_rd;     // read entry j-1 of prev
		logic     ld_wr;     // write entry j of loaded node
		logic     q_setup;   // order nodes by level, form difference
		logic     lift_rd;   // read entry j of u
		logic     lift_wr;   // u <= read data
		logic     tog_rd;    // read entry j of u and v
		logic     tog_wr;    // step u and v where ancestors differ
		logic     fin_rd;    // read parent of u
		logic     j_top;     // j <= LEVELS-1
		logic     jdec;      // j <= j-1
		logic     res_load;
		res_sel_t res_sel;
		logic     out_push;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mode;
		logic load_bad;
		logic range_bad;
		logic same;
		logic single_level;
		logic ld_last;
		logic j_zero;
		logic lift_bit;
		logic uv_eq;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/core/lowest_common_ancestor_lifting_core.sv @@
// Load: accepted, then busy filling the ancestor row, no result.
// Query: result registered after lifting the deeper node (S_LIFT, plus S_LIFT_WR for a set bit),
//   then joint steps (S_TOG_RD, S_TOG_WR) and S_FIN_RD, S_FIN_WR, unless lifting alone meets the
//   shallower node; range or equal-node queries go from S_DECIDE straight to S_RESULT.
// One item in work at a time, next item taken once the controller is back in idle; the
//   output register lets the next item start while a result waits. Reset: arst_n async low.
`default_nettype none
module lowest_common_ancestor_lifting_core
	import lcal_pkg::*;
#(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,  // node_a[9:0], node_b[19:10], zero [23:20]
	input  wire  [0:0]  s_axis_tuser,  // mode[0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata   // ancestor[9:0], zero [15:10]
);

	cmd_t              cmd;
	stat_t             stat;
	logic [NODE_W-1:0] ancestor;

	lcal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lcal_dpath #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (s_axis_tuser[0]),
		.node_a    (s_axis_tdata[9:0]),
		.node_b    (s_axis_tdata[19:10]),
		.cmd       (cmd),
		.stat      (stat),
		.ancestor  (ancestor),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {6'b0, ancestor};

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while previous item still in work");

	// table read port address mux relies on exclusive read commands
	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_rd, cmd.lift_rd, cmd.tog_rd, cmd.fin_rd}))
		else $error("conflicting table read commands");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ld_start && cmd.ld_wr))
		else $error("conflicting table write commands");

	// a result is never pushed over one still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_push |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result pushed into occupied output register");

endmodule
`default_nettype wire

@@ rtl/core/lcal_ctrl.sv @@
// Sequencer for load fills and query lifting passes.
`default_nettype none
module lcal_ctrl
	import lcal_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_DECIDE  = 12'b000000000010,
		S_LD_RD   = 12'b000000000100,
		S_LD_WR   = 12'b000000001000,
		S_LIFT    = 12'b000000010000,
		S_LIFT_WR = 12'b000000100000,
		S_CHECK   = 12'b000001000000,
		S_TOG_RD  = 12'b000010000000,
		S_TOG_WR  = 12'b000100000000,
		S_FIN_RD  = 12'b001000000000,
		S_FIN_WR  = 12'b010000000000,
		S_RESULT  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.mode == MODE_LOAD) begin
					if (stat.load_bad) begin
						state_d = S_IDLE;
					end else begin
						cmd.ld_start = 1'b1;
						state_d = stat.single_level ? S_IDLE : S_LD_RD;
					end
				end else if (stat.range_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_d      = S_RESULT;
				end else if (stat.same) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_NODE_A;
					state_d      = S_RESULT;
				end else begin
					cmd.q_setup = 1'b1;
					state_d     = S_LIFT;
				end
			end
			S_LD_RD: begin
				cmd.ld_rd = 1'b1;
				state_d   = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = stat.ld_last ? S_IDLE : S_LD_RD;
			end
			S_LIFT: begin
				if (stat.lift_bit) begin
					cmd.lift_rd = 1'b1;
					state_d     = S_LIFT_WR;
				end else if (stat.j_zero) begin
					state_d = S_CHECK;
				end else begin
					cmd.jdec = 1'b1;
				end
			end
			S_LIFT_WR: begin
				cmd.lift_wr = 1'b1;
				if (stat.j_zero) begin
					state_d = S_CHECK;
				end else begin
					cmd.jdec = 1'b1;
					state_d  = S_LIFT;
				end
			end
			S_CHECK: begin
				if (stat.uv_eq) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_U;
					state_d      = S_RESULT;
				end else begin
					cmd.j_top = 1'b1;
					state_d   = S_TOG_RD;
				end
			end
			S_TOG_RD: begin
				cmd.tog_rd = 1'b1;
				state_d    = S_TOG_WR;
			end
			S_TOG_WR: begin
				cmd.tog_wr = 1'b1;
				if (stat.j_zero) begin
					state_d = S_FIN_RD;
				end else begin
					cmd.jdec = 1'b1;
					state_d  = S_TOG_RD;
				end
			end
			S_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_d    = S_FIN_WR;
			end
			S_FIN_WR: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_RD;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/lcal_dpath.sv @@
// Datapath: ancestor table, level store, lifting registers and output register.
`default_nettype none
module lcal_dpath
	import lcal_pkg::*;
#(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               mode,
	input  wire  [NODE_W-1:0] node_a,
	input  wire  [NODE_W-1:0] node_b,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic [NODE_W-1:0] ancestor,
	output logic              out_valid,
	input  wire               out_ready
);

	localparam int NW = $clog2(NODES);
	localparam int JW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AW = NW + JW;
	localparam logic [JW-1:0] J_TOP = JW'(LEVELS - 1);

	// row of node 0 and its level are never written; reads of node 0 return zero
	logic [NODE_W-1:0] jt_mem [0:(2**AW)-1];
	logic [NODE_W-1:0] lv_mem [0:(2**NW)-1];

	logic              mode_q;
	logic [NODE_W-1:0] a_q, b_q, u_q, v_q, prev_q, diff_q, res_q, out_q;
	logic [JW-1:0]     j_q;
	logic              out_valid_q;

	logic [NODE_W-1:0] rda_raw_q, rdb_raw_q, lva_raw_q, lvb_raw_q;
	logic              rda_zero_q, rdb_zero_q, lva_zero_q, lvb_zero_q;
	logic [NODE_W-1:0] rda_val, rdb_val, lva_val, lvb_val, lvl_next;

	logic [NODE_W-1:0] ra_node;
	logic [JW-1:0]     ra_j, wa_j;
	logic              ra_en, we;
	logic [NODE_W-1:0] wd;
	logic [15:0]       diff_ext;

	assign rda_val = rda_zero_q ? '0 : rda_raw_q;
	assign rdb_val = rdb_zero_q ? '0 : rdb_raw_q;
	assign lva_val = lva_zero_q ? '0 : lva_raw_q;
	assign lvb_val = lvb_zero_q ? '0 : lvb_raw_q;
	assign lvl_next = (lvb_val == LVL_MAX) ? LVL_MAX : NODE_W'(lvb_val + 1'b1);

	always_comb begin
		ra_node = u_q;
		ra_j    = j_q;
		if (cmd.ld_rd) begin
			ra_node = prev_q;
			ra_j    = JW'(j_q - 1'b1);
		end else if (cmd.fin_rd) begin
			ra_j = '0;
		end
	end

	assign ra_en = cmd.ld_rd | cmd.lift_rd | cmd.tog_rd | cmd.fin_rd;
	assign we    = cmd.ld_start | cmd.ld_wr;
	assign wa_j  = cmd.ld_start ? '0 : j_q;
	assign wd    = cmd.ld_start ? b_q : rda_val;

	always_ff @(posedge clk) begin
		if (we) begin
			jt_mem[{NW'(a_q), wa_j}] <= wd;
		end
		if (ra_en) begin
			rda_raw_q  <= jt_mem[{NW'(ra_node), ra_j}];
			rda_zero_q <= (ra_node == '0);
		end
		if (cmd.tog_rd) begin
			rdb_raw_q  <= jt_mem[{NW'(v_q), j_q}];
			rdb_zero_q <= (v_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			lv_mem[NW'(a_q)] <= lvl_next;
		end
		if (cmd.cap) begin
			lva_raw_q  <= lv_mem[NW'(node_a)];
			lvb_raw_q  <= lv_mem[NW'(node_b)];
			lva_zero_q <= (node_a == '0);
			lvb_zero_q <= (node_b == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode;
			a_q    <= node_a;
			b_q    <= node_b;
		end
		if (cmd.ld_start) begin
			prev_q <= b_q;
		end else if (cmd.ld_wr) begin
			prev_q <= rda_val;
		end
		if (cmd.q_setup) begin
			if (lva_val < lvb_val) begin
				u_q    <= b_q;
				v_q    <= a_q;
				diff_q <= NODE_W'(lvb_val - lva_val);
			end else begin
				u_q    <= a_q;
				v_q    <= b_q;
				diff_q <= NODE_W'(lva_val - lvb_val);
			end
		end else if (cmd.lift_wr) begin
			u_q <= rda_val;
		end else if (cmd.tog_wr && (rda_val != rdb_val)) begin
			u_q <= rda_val;
			v_q <= rdb_val;
		end
		if (cmd.ld_start) begin
			j_q <= JW'(1);
		end else if (cmd.ld_wr) begin
			j_q <= JW'(j_q + 1'b1);
		end else if (cmd.q_setup || cmd.j_top) begin
			j_q <= J_TOP;
		end else if (cmd.jdec) begin
			j_q <= JW'(j_q - 1'b1);
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_ZERO:   res_q <= '0;
				RES_NODE_A: res_q <= a_q;
				RES_U:      res_q <= u_q;
				RES_RD:     res_q <= rda_val;
				default:    res_q <= '0;
			endcase
		end
		if (cmd.out_push) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign ancestor  = out_q;
	assign out_valid = out_valid_q;

	// level difference is at most 10 bits; higher lift steps see zero
	assign diff_ext = {6'b0, diff_q};

	always_comb begin
		stat              = '0;
		stat.mode         = mode_q;
		stat.range_bad    = (32'(a_q) >= NODES) || (32'(b_q) >= NODES);
		stat.load_bad     = stat.range_bad || (a_q == '0);
		stat.same         = (a_q == b_q);
		stat.single_level = (LEVELS == 1);
		stat.ld_last      = (j_q == J_TOP);
		stat.j_zero       = (j_q == '0);
		stat.lift_bit     = diff_ext[4'(j_q)];
		stat.uv_eq        = (u_q == v_q);
		stat.out_free     = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire
